/* rtl/rotated_box_bounds_top_defines.svh */
// Assertion macros for the rotated box bounds block.
// Included by modules that carry concurrent checks; needs nothing else.
`ifndef ROTATED_BOX_BOUNDS_TOP_DEFINES_SVH
`define ROTATED_BOX_BOUNDS_TOP_DEFINES_SVH
// check that an implication holds outside reset
`define RBB_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// check that an implication holds in the cycle after the antecedent
`define RBB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

/* rtl/rbb_pkg.sv */
// Package for the rotated box bounds block: widths, register indexes, rounding, saturation.
// No dependencies.
`default_nettype none
package rbb_pkg;
	localparam int CoordW = 32;
	localparam int CoefW  = 16;
	localparam int DiffW  = 33;
	localparam int ProdW  = 50;
	localparam int RotW   = 36;
	localparam int FracSh = 15;
	localparam int NCorner = 8;
	localparam int AddrW  = 2;
	localparam logic [AddrW-1:0] REG_AZ_SIN = 2'd0;
	localparam logic [AddrW-1:0] REG_AZ_COS = 2'd1;
	localparam logic [AddrW-1:0] REG_IN_SIN = 2'd2;
	localparam logic [AddrW-1:0] REG_IN_COS = 2'd3;
	localparam logic signed [CoefW-1:0] COEF_ONE = 16'sh7FFF;

	typedef logic signed [DiffW-1:0] diff_t;
	typedef logic signed [ProdW-1:0] prod_t;
	typedef logic signed [RotW-1:0]  rot_t;

	// floor((v + 2^14) / 2^15) on a sum of two products
	function automatic rot_t round_q(input logic signed [ProdW:0] v);
		logic signed [ProdW:0] t;
		t = v + (ProdW+1)'(1 << (FracSh-1));
		return rot_t'(t >>> FracSh);
	endfunction

	// clamp to signed 32 bits
	function automatic logic signed [CoordW-1:0] sat32(input rot_t v);
		if (v > rot_t'(32'sh7FFFFFFF)) return 32'sh7FFFFFFF;
		if (v < -rot_t'(33'sh080000000)) return 32'sh80000000;
		return v[CoordW-1:0];
	endfunction
endpackage
`default_nettype wire

/* rtl/rbb_corner.sv */
// One corner lane: azimuth then inclination rotation over four registered stages.
// Depends on rbb_pkg.
`default_nettype none
module rbb_corner import rbb_pkg::*; (
	input  wire logic clk,
	input  wire logic en,
	input  wire diff_t dx,
	input  wire diff_t dy,
	input  wire diff_t dz,
	input  wire logic signed [CoefW-1:0] sa,
	input  wire logic signed [CoefW-1:0] ca,
	input  wire logic signed [CoefW-1:0] si,
	input  wire logic signed [CoefW-1:0] ci,
	output rot_t rx,
	output rot_t ry,
	output rot_t rz
);
	prod_t p_xc_s1, p_ys_s1, p_xs_s1, p_yc_s1;
	diff_t dz_s1;
	rot_t rx_s2, q_s2;
	diff_t dz_s2;
	prod_t p_qc_s3, p_zs_s3, p_qs_s3, p_zc_s3;
	rot_t rx_s3;
	rot_t rx_s4, ry_s4, rz_s4;

	// multiply by the azimuth terms, round, multiply by inclination, round
	always_ff @(posedge clk) begin
		if (en) begin
			p_xc_s1 <= prod_t'(dx * ca);
			p_ys_s1 <= prod_t'(dy * sa);
			p_xs_s1 <= prod_t'(dx * sa);
			p_yc_s1 <= prod_t'(dy * ca);
			dz_s1   <= dz;
			rx_s2   <= round_q((ProdW+1)'(p_xc_s1) - (ProdW+1)'(p_ys_s1));
			q_s2    <= round_q((ProdW+1)'(p_xs_s1) + (ProdW+1)'(p_yc_s1));
			dz_s2   <= dz_s1;
			p_qc_s3 <= prod_t'(q_s2 * ci);
			p_zs_s3 <= prod_t'(dz_s2 * si);
			p_qs_s3 <= prod_t'(q_s2 * si);
			p_zc_s3 <= prod_t'(dz_s2 * ci);
			rx_s3   <= rx_s2;
			rx_s4   <= rx_s3;
			ry_s4   <= round_q((ProdW+1)'(p_qc_s3) - (ProdW+1)'(p_zs_s3));
			rz_s4   <= round_q((ProdW+1)'(p_qs_s3) + (ProdW+1)'(p_zc_s3));
		end
	end
	assign rx = rx_s4;
	assign ry = ry_s4;
	assign rz = rz_s4;
endmodule
`default_nettype wire

/* rtl/rbb_minmax.sv */
// Registered min/max tree over the eight rotated corners, then saturation.
// Depends on rbb_pkg.
`default_nettype none
module rbb_minmax import rbb_pkg::*; (
	input  wire logic clk,
	input  wire logic en,
	input  wire rot_t v [NCorner],
	output logic signed [CoordW-1:0] lo,
	output logic signed [CoordW-1:0] hi
);
	rot_t lo_s1 [4], hi_s1 [4];
	rot_t lo_s2 [2], hi_s2 [2];
	logic signed [CoordW-1:0] lo_s3, hi_s3;

	// reduce pairwise, one level per stage; saturate on the last
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				lo_s1[i] <= (v[2*i] < v[2*i+1]) ? v[2*i] : v[2*i+1];
				hi_s1[i] <= (v[2*i] > v[2*i+1]) ? v[2*i] : v[2*i+1];
			end
			for (int i = 0; i < 2; i++) begin
				lo_s2[i] <= (lo_s1[2*i] < lo_s1[2*i+1]) ? lo_s1[2*i] : lo_s1[2*i+1];
				hi_s2[i] <= (hi_s1[2*i] > hi_s1[2*i+1]) ? hi_s1[2*i] : hi_s1[2*i+1];
			end
			lo_s3 <= sat32((lo_s2[0] < lo_s2[1]) ? lo_s2[0] : lo_s2[1]);
			hi_s3 <= sat32((hi_s2[0] > hi_s2[1]) ? hi_s2[0] : hi_s2[1]);
		end
	end
	assign lo = lo_s3;
	assign hi = hi_s3;
endmodule
`default_nettype wire

/* rtl/rotated_box_bounds_top.sv */
// Top level of the rotated box bounds block: config registers, pipeline, output.
// Depends on rbb_pkg, rbb_corner, rbb_minmax and the assertion macro header.
//
// channel | dir | word
// s_axis  | in  | box min xyz, box max xyz, pivot xyz (288 bits)
// m_axis  | out | out min xyz, out max xyz (192 bits)
// cfg     | in  | cfg_we, cfg_addr, cfg_data (16 bits)
//
// One box per cycle while not stalled; stages: subtract, 4 rotation, 3 min/max.
// The whole pipeline advances together; m_axis_tready low with m_axis_tvalid high freezes it.
// Reset clears valid bits and sets the coefficients to identity.
`default_nettype none
`include "rotated_box_bounds_top_defines.svh"
module rotated_box_bounds_top import rbb_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_axis_tvalid,
	output logic s_axis_tready,
	// box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z, pivot_x..z
	input  wire logic [9*CoordW-1:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  wire logic m_axis_tready,
	// out_min_x, out_min_y, out_min_z, out_max_x, out_max_y, out_max_z
	output logic [6*CoordW-1:0] m_axis_tdata,
	input  wire logic cfg_we,
	input  wire logic [AddrW-1:0] cfg_addr,
	input  wire logic [CoefW-1:0] cfg_data
);
	localparam int Depth = 8;
	logic signed [CoefW-1:0] sa_q, ca_q, si_q, ci_q;
	logic [Depth-1:0] vld_q;
	logic en;
	diff_t lo_s1 [3], hi_s1 [3];
	rot_t r [3][NCorner];
	logic signed [CoordW-1:0] omin [3], omax [3];

	// hold coefficients
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sa_q <= '0; ca_q <= COEF_ONE; si_q <= '0; ci_q <= COEF_ONE;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_AZ_SIN: sa_q <= cfg_data;
				REG_AZ_COS: ca_q <= cfg_data;
				REG_IN_SIN: si_q <= cfg_data;
				REG_IN_COS: ci_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// advance when the output slot is empty or being taken
	assign en = !vld_q[Depth-1] || m_axis_tready;
	assign s_axis_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (en) vld_q <= {vld_q[Depth-2:0], s_axis_tvalid};
	end

	// subtract pivot
	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < 3; a++) begin
				lo_s1[a] <= diff_t'($signed(s_axis_tdata[a*CoordW +: CoordW]))
					- diff_t'($signed(s_axis_tdata[(6+a)*CoordW +: CoordW]));
				hi_s1[a] <= diff_t'($signed(s_axis_tdata[(3+a)*CoordW +: CoordW]))
					- diff_t'($signed(s_axis_tdata[(6+a)*CoordW +: CoordW]));
			end
		end
	end

	for (genvar k = 0; k < NCorner; k++) begin : g_corner
		rbb_corner u_corner (
			.clk(clk), .en(en),
			.dx(((k & 1) != 0) ? hi_s1[0] : lo_s1[0]),
			.dy(((k & 2) != 0) ? hi_s1[1] : lo_s1[1]),
			.dz(((k & 4) != 0) ? hi_s1[2] : lo_s1[2]),
			.sa(sa_q), .ca(ca_q), .si(si_q), .ci(ci_q),
			.rx(r[0][k]), .ry(r[1][k]), .rz(r[2][k])
		);
	end

	for (genvar a = 0; a < 3; a++) begin : g_axis
		rbb_minmax u_mm (.clk(clk), .en(en), .v(r[a]), .lo(omin[a]), .hi(omax[a]));
		assign m_axis_tdata[a*CoordW +: CoordW]     = omin[a];
		assign m_axis_tdata[(3+a)*CoordW +: CoordW] = omax[a];
	end
	assign m_axis_tvalid = vld_q[Depth-1];

	`RBB_ASSERT_NEXT(a_stall_holds, m_axis_tvalid && !m_axis_tready, vld_q == $past(vld_q), "pipeline moved while stalled")
	`RBB_ASSERT_IMPL(a_ready_free, !m_axis_tvalid, s_axis_tready, "ready low with empty output")
	`RBB_ASSERT_NEXT(a_take_enters, s_axis_tvalid && s_axis_tready, vld_q[0], "accepted word lost")
endmodule
`default_nettype wire
